>>> src/dsg_pkg.sv
`timescale 1ns / 1ps
package dsg_pkg;
   localparam int DATA_WIDTH = 32;
   localparam logic [DATA_WIDTH-1:0] RESET_P = 32'd283;
   localparam logic [DATA_WIDTH-1:0] RESET_Q = 32'd47;
   localparam logic [DATA_WIDTH-1:0] RESET_G = 32'd60;
   localparam logic [DATA_WIDTH-1:0] RESET_X = 32'd24;
   localparam int CSR_INDEX_WIDTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_P = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Q = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_G = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X = 2'd3;

   // command selectors
   localparam logic [2:0] SEL_MAIN    = 3'd0;   // default variant of an operation
   localparam logic [2:0] SEL_ALT     = 3'd1;   // latch the previous unit result first
   localparam logic [2:0] SEL_REDUCED = 3'd2;   // take the reducer remainder as base

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,     // latch inputs, start the reduction g%p, copy k and q for Euclid
      OP_MOD,      // one step of the shared restoring reducer/divider
      OP_MUL,      // one step of the shared double-and-add multiplier
      OP_SETUP_POW_SQ,
      OP_SETUP_POW_MUL,
      OP_POW_SHIFT,
      OP_SETUP_R,
      OP_SETUP_EUCLID_DIV,
      OP_SETUP_EUCLID_MUL,
      OP_EUCLID_UPDATE,
      OP_SETUP_HASH,
      OP_SETUP_XR,
      OP_SETUP_S,
      OP_OUTPUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic [2:0] sel;     // destination / source selector
   } cmd_type;

   typedef struct packed {
      logic unit_done;     // multi-cycle unit is on its last step
      logic exp_zero;      // exponent fully consumed
      logic exp_bit;       // current exponent bit
      logic r1_zero;       // Euclid remainder zero
      logic q_zero;
      logic p_zero;
   } sts_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RED_G, ST_RED_G_W, ST_ACC_INIT, ST_ACC_INIT_W, ST_POW_TEST,
      ST_POW_MUL, ST_POW_MUL_W, ST_POW_SQ, ST_POW_SQ_W, ST_POW_SHIFT,
      ST_R, ST_R_W, ST_EU_TEST, ST_EU_DIV, ST_EU_DIV_W, ST_EU_QM, ST_EU_QM_W,
      ST_EU_MUL, ST_EU_MUL_W, ST_EU_UPD, ST_HASH, ST_HASH_W, ST_XQ, ST_XQ_W,
      ST_XR, ST_XR_W, ST_S, ST_S_W, ST_OUT
   } state_type;
endpackage

>>> src/dsg_datapath.sv
`timescale 1ns / 1ps
module dsg_datapath #(
   parameter int WIDTH = dsg_pkg::DATA_WIDTH
) (
   input  logic               clock,
   input  dsg_pkg::cmd_type   cmd,
   output dsg_pkg::sts_type   sts,
   input  logic [WIDTH-1:0]   in_hash,
   input  logic [WIDTH-1:0]   in_k,
   input  logic [WIDTH-1:0]   cfg_p,
   input  logic [WIDTH-1:0]   cfg_q,
   input  logic [WIDTH-1:0]   cfg_g,
   input  logic [WIDTH-1:0]   cfg_x,
   output logic [WIDTH-1:0]   out_r,
   output logic [WIDTH-1:0]   out_s
);
   import dsg_pkg::*;
   localparam int CW = $clog2(WIDTH + 1);
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   // working registers
   logic [WIDTH-1:0] hash_ff, exp_ff, base_ff, acc_ff, r_ff;
   logic [WIDTH-1:0] r0_ff, r1_ff, c0_ff, c1_ff, sum_ff;
   // shared unit: operands a, b, modulus m, result res
   logic [WIDTH-1:0] ua_ff, ub_ff, um_ff, res_ff, rem_ff;
   logic [CW-1:0]    cnt_ff;
   logic             is_div_ff;

   // one step of the unit
   logic [WIDTH:0] dbl, dbl_red, add, add_red, shr;
   logic [WIDTH-1:0] mul_next, rem_next;
   logic bitv;
   always_comb begin
      bitv = ub_ff[WIDTH-1-cnt_ff[CW-1:0]];
      dbl = {res_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, um_ff}) ? dbl - {1'b0, um_ff} : dbl;
      add = dbl_red + {1'b0, ua_ff};
      add_red = (add >= {1'b0, um_ff}) ? add - {1'b0, um_ff} : add;
      mul_next = bitv ? add_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
      // restoring division: remainder shifts in next dividend bit
      shr = {rem_ff, bitv};
      rem_next = (shr >= {1'b0, um_ff}) ? WIDTH'(shr - {1'b0, um_ff}) : shr[WIDTH-1:0];
   end

   logic [WIDTH-1:0] sub_t;
   always_comb sub_t = (c0_ff >= res_ff) ? c0_ff - res_ff : c0_ff + (cfg_q - res_ff);

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            hash_ff <= in_hash; exp_ff <= in_k;
            r0_ff <= in_k; r1_ff <= cfg_q;
            c0_ff <= (cfg_q == WIDTH'(1)) ? '0 : WIDTH'(1); c1_ff <= '0;
            acc_ff <= (cfg_p == WIDTH'(1)) ? '0 : WIDTH'(1);
            // reduce g mod p
            ub_ff <= cfg_g; um_ff <= cfg_p; rem_ff <= '0; res_ff <= '0;
            is_div_ff <= 1'b1; cnt_ff <= '0;
         end
         OP_MOD, OP_MUL: begin
            if (is_div_ff) begin
               rem_ff <= rem_next;
               res_ff <= {res_ff[WIDTH-2:0], (shr >= {1'b0, um_ff})};
            end else begin
               res_ff <= mul_next;
            end
            cnt_ff <= cnt_ff + CW'(1);
         end
         OP_SETUP_POW_MUL: begin
            ua_ff <= acc_ff; ub_ff <= base_ff; um_ff <= cfg_p;
            res_ff <= '0; is_div_ff <= 1'b0; cnt_ff <= '0;
         end
         OP_SETUP_POW_SQ: begin
            if (cmd.sel == SEL_ALT) acc_ff <= res_ff;
            else if (cmd.sel == SEL_REDUCED) base_ff <= rem_ff;
            ua_ff <= (cmd.sel == SEL_REDUCED) ? rem_ff : base_ff;
            ub_ff <= (cmd.sel == SEL_REDUCED) ? rem_ff : base_ff;
            um_ff <= cfg_p; res_ff <= '0; is_div_ff <= 1'b0; cnt_ff <= '0;
         end
         OP_POW_SHIFT: begin
            base_ff <= res_ff; exp_ff <= exp_ff >> 1;
         end
         OP_SETUP_R: begin
            ub_ff <= (cfg_p == '0) ? '0 : acc_ff; um_ff <= cfg_q;
            rem_ff <= '0; res_ff <= '0; is_div_ff <= 1'b1; cnt_ff <= '0;
         end
         OP_SETUP_EUCLID_DIV: begin
            if (cmd.sel == SEL_ALT) r_ff <= rem_ff;
            ub_ff <= r0_ff; um_ff <= r1_ff;
            rem_ff <= '0; res_ff <= '0; is_div_ff <= 1'b1; cnt_ff <= '0;
         end
         OP_SETUP_EUCLID_MUL: begin
            // quotient mod q, then c1 times that mod q
            if (cmd.sel == SEL_MAIN) begin
               ub_ff <= res_ff; um_ff <= cfg_q;
               rem_ff <= '0; res_ff <= '0; is_div_ff <= 1'b1; cnt_ff <= '0;
               sum_ff <= rem_ff;
            end else begin
               ua_ff <= c1_ff; ub_ff <= rem_ff; um_ff <= cfg_q;
               res_ff <= '0; is_div_ff <= 1'b0; cnt_ff <= '0;
            end
         end
         OP_EUCLID_UPDATE: begin
            r0_ff <= r1_ff; r1_ff <= sum_ff;
            c0_ff <= c1_ff; c1_ff <= sub_t;
         end
         OP_SETUP_HASH: begin
            ub_ff <= hash_ff; um_ff <= cfg_q;
            rem_ff <= '0; res_ff <= '0; is_div_ff <= 1'b1; cnt_ff <= '0;
         end
         OP_SETUP_XR: begin
            if (cmd.sel == SEL_MAIN) begin
               sum_ff <= rem_ff; ub_ff <= cfg_x;
               rem_ff <= '0; res_ff <= '0; is_div_ff <= 1'b1; cnt_ff <= '0;
            end else begin
               ua_ff <= rem_ff; ub_ff <= r_ff; res_ff <= '0;
               is_div_ff <= 1'b0; cnt_ff <= '0;
            end
         end
         OP_SETUP_S: begin
            ua_ff <= c0_ff;
            ub_ff <= (sum_ff >= cfg_q - res_ff) ? sum_ff - (cfg_q - res_ff)
                                                 : sum_ff + res_ff;
            res_ff <= '0; is_div_ff <= 1'b0; cnt_ff <= '0;
         end
         OP_OUTPUT: begin
            if (cfg_q <= WIDTH'(1)) begin
               out_r <= '0; out_s <= '0;
            end else begin
               out_r <= r_ff; out_s <= res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sts.unit_done = (cnt_ff == LAST);
      sts.exp_zero  = (exp_ff == '0);
      sts.exp_bit   = exp_ff[0];
      sts.r1_zero   = (r1_ff == '0);
      sts.q_zero    = (cfg_q == '0);
      sts.p_zero    = (cfg_p == '0);
   end
endmodule

>>> src/dsg_controller.sv
`timescale 1ns / 1ps
module dsg_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             done,
   input  logic             rsp_taken,
   output dsg_pkg::cmd_type cmd,
   input  dsg_pkg::sts_type sts
);
   import dsg_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      cmd.sel = SEL_MAIN;
      busy = 1'b1;
      done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.op = OP_LOAD;
               state_in = ST_RED_G_W;
            end
         end
         ST_RED_G_W: begin
            cmd.op = OP_MOD;
            if (sts.unit_done) state_in = ST_RED_G;
         end
         ST_RED_G: begin
            // base <= g mod p, then test exponent
            cmd.op = OP_SETUP_POW_SQ; cmd.sel = SEL_REDUCED;
            state_in = ST_POW_TEST;
         end
         ST_POW_TEST: begin
            if (sts.p_zero || sts.exp_zero) state_in = ST_R;
            else if (sts.exp_bit) begin
               cmd.op = OP_SETUP_POW_MUL; state_in = ST_POW_MUL_W;
            end else begin
               cmd.op = OP_SETUP_POW_SQ; state_in = ST_POW_SQ_W;
            end
         end
         ST_POW_MUL_W: begin
            cmd.op = OP_MUL;
            if (sts.unit_done) state_in = ST_POW_MUL;
         end
         ST_POW_MUL: begin
            cmd.op = OP_SETUP_POW_SQ; cmd.sel = SEL_ALT;
            state_in = ST_POW_SQ_W;
         end
         ST_POW_SQ_W: begin
            cmd.op = OP_MUL;
            if (sts.unit_done) state_in = ST_POW_SHIFT;
         end
         ST_POW_SHIFT: begin
            cmd.op = OP_POW_SHIFT; state_in = ST_POW_TEST;
         end
         ST_R: begin
            if (sts.q_zero) state_in = ST_OUT;
            else begin
               cmd.op = OP_SETUP_R; state_in = ST_R_W;
            end
         end
         ST_R_W: begin
            cmd.op = OP_MOD;
            if (sts.unit_done) state_in = ST_EU_TEST;
         end
         ST_EU_TEST: begin
            // first pass latches r from the reducer
            cmd.op = OP_SETUP_EUCLID_DIV; cmd.sel = SEL_ALT;
            state_in = sts.r1_zero ? ST_HASH : ST_EU_DIV_W;
         end
         ST_EU_DIV: begin
            cmd.op = OP_SETUP_EUCLID_DIV;
            state_in = sts.r1_zero ? ST_HASH : ST_EU_DIV_W;
         end
         ST_EU_DIV_W: begin
            cmd.op = OP_MOD;
            if (sts.unit_done) state_in = ST_EU_QM;
         end
         ST_EU_QM: begin
            cmd.op = OP_SETUP_EUCLID_MUL; state_in = ST_EU_QM_W;
         end
         ST_EU_QM_W: begin
            cmd.op = OP_MOD;
            if (sts.unit_done) state_in = ST_EU_MUL;
         end
         ST_EU_MUL: begin
            cmd.op = OP_SETUP_EUCLID_MUL; cmd.sel = SEL_ALT;
            state_in = ST_EU_MUL_W;
         end
         ST_EU_MUL_W: begin
            cmd.op = OP_MUL;
            if (sts.unit_done) state_in = ST_EU_UPD;
         end
         ST_EU_UPD: begin
            cmd.op = OP_EUCLID_UPDATE; state_in = ST_EU_DIV;
         end
         ST_HASH: begin
            cmd.op = OP_SETUP_HASH; state_in = ST_HASH_W;
         end
         ST_HASH_W: begin
            cmd.op = OP_MOD;
            if (sts.unit_done) state_in = ST_XQ;
         end
         ST_XQ: begin
            cmd.op = OP_SETUP_XR; state_in = ST_XQ_W;
         end
         ST_XQ_W: begin
            cmd.op = OP_MOD;
            if (sts.unit_done) state_in = ST_XR;
         end
         ST_XR: begin
            cmd.op = OP_SETUP_XR; cmd.sel = SEL_ALT; state_in = ST_XR_W;
         end
         ST_XR_W: begin
            cmd.op = OP_MUL;
            if (sts.unit_done) state_in = ST_S;
         end
         ST_S: begin
            cmd.op = OP_SETUP_S; state_in = ST_S_W;
         end
         ST_S_W: begin
            cmd.op = OP_MUL;
            if (sts.unit_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            // load the output register once it is free
            if (rsp_taken) begin
               cmd.op = OP_OUTPUT; done = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

>>> src/dsa_signature_generator_unit.sv
`timescale 1ns / 1ps
// A run takes longer for each bit of k up to its top set bit, more for a set bit than a clear one,
// and for each Euclid step; it is shorter when p or q is zero. All multiplications and reductions
// run on the single shared one-bit-a-cycle unit.
// One transaction at a time; the next is taken in the cycle after the result
// is loaded into the output register, which waits while a result stalls.
// Synchronous active-high reset restores p=283, q=47, g=60, x=24 and empties the output.
module dsa_signature_generator_unit #(
   parameter int WIDTH = dsg_pkg::DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2*WIDTH-1:0]  req_tdata,   // message_hash, nonce_k
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [2*WIDTH-1:0]  rsp_tdata,   // sig_r, sig_s
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [dsg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WIDTH-1:0]    csr_data
);
   import dsg_pkg::*;
   logic [WIDTH-1:0] p_ff, q_ff, g_ff, x_ff, out_r, out_s;
   logic rsp_valid_ff, busy, done, start;
   cmd_type cmd;
   sts_type sts;

   // configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= WIDTH'(RESET_P); q_ff <= WIDTH'(RESET_Q);
         g_ff <= WIDTH'(RESET_G); x_ff <= WIDTH'(RESET_X);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_P: p_ff <= csr_data;
            CSR_Q: q_ff <= csr_data;
            CSR_G: g_ff <= csr_data;
            CSR_X: x_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = !busy;
   assign start = req_tvalid && !busy;

   // output valid holds until the transaction is taken
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {out_s, out_r};

   dsg_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .done(done),
      .rsp_taken(!rsp_valid_ff || rsp_tready), .cmd(cmd), .sts(sts)
   );

   dsg_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock(clock), .cmd(cmd), .sts(sts),
      .in_hash(req_tdata[WIDTH-1:0]), .in_k(req_tdata[2*WIDTH-1:WIDTH]),
      .cfg_p(p_ff), .cfg_q(q_ff), .cfg_g(g_ff), .cfg_x(x_ff),
      .out_r(out_r), .out_s(out_s)
   );
endmodule
